/* rtl/core/fcdr_pkg.sv */
// Shared constants and types for the four-channel duty ramp profile core.
package fcdr_pkg;

    localparam int CHANNELS = 4;
    localparam int OUT_CH   = 4;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int DUTY_W   = 8;
    localparam int DUR_W    = 16;
    localparam int RAMP_W   = 13;
    localparam int PHASE_W  = 2;

    // Two quotient bits per cycle over an 8-bit dividend.
    localparam int DIV_STEPS = DUTY_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // duration / 10 as (duration * 52429) >> 19, exact over 16-bit inputs
    localparam int            RECIP_W     = 17;
    localparam logic [16:0]   RECIP_TEN   = 17'd52429;
    localparam int            RECIP_SHIFT = 19;
    localparam int            PROD_W      = DUR_W + RECIP_W;

    localparam int IN_DATA_W  = 4 * DUTY_W + DUR_W;
    localparam int OUT_DATA_W = OUT_CH * DUTY_W;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_UP   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DOWN = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Source of the duties shown in a result.
    typedef enum logic [1:0] {
        SHOW_ZERO   = 2'd0,
        SHOW_TARGET = 2'd1,
        SHOW_DUTY   = 2'd2
    } show_t;

endpackage

/* rtl/core/four_channel_duty_ramp_profile_core.sv */
// Four-channel trapezoidal duty ramp generator with a shared 2-bit-per-cycle divider.
//
// Input stream (s_axis_*): tuser is the command, 0 = tick, 1 = start a move.
// A start request latches four target duties and a duration in ticks; the ramp
// length is duration/10 and the hold length is the rest after both ramps. Each tick request
// returns one set of duties, the phase after the tick (tuser) and tlast on the
// tick that finishes the move.
// Output stream (m_axis_*): one result per request, held in an output register.
//
// Timing: a ramp tick walks the channels through one restoring divider, two
// quotient bits a cycle; the result register loads in the finish state and the
// sequencer then returns to idle to take the next request. Start requests pass
// through the start state to finish, hold and idle ticks go straight to finish.
// s_axis_tready is high only while the sequencer is idle; the next request may
// be accepted while a result still waits.
// If the receiver stalls, a finished result waits in the sequencer until the
// output register frees up.
// Reset: asynchronous, active low; the block comes up idle with no move running.
module four_channel_duty_ramp_profile_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // target_left_a, target_left_b, target_right_a, target_right_b, duration
    input  logic [fcdr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // duty_left_a, duty_left_b, duty_right_a, duty_right_b
    output logic [fcdr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // phase_now
    output logic [fcdr_pkg::PHASE_W-1:0]        m_axis_tuser,
    // move_done
    output logic                                m_axis_tlast
);

    import fcdr_pkg::*;

    state_t                 state_reg, state_next;
    logic [PHASE_W-1:0]     phase_reg;
    logic [DUR_W-1:0]       step_reg;
    logic [RAMP_W-1:0]      ramp_reg;
    logic [DUR_W-1:0]       hold_reg;
    logic [DUR_W-1:0]       dur_reg;
    logic [DUR_W-1:0]       divisor_reg;
    logic                   op_up_reg;
    show_t                  show_reg;
    logic                   done_reg;

    logic [DUTY_W-1:0]      cur_reg [CHANNELS];
    logic [DUTY_W-1:0]      tgt_reg [CHANNELS];

    logic [CH_W-1:0]        ch_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DUTY_W-1:0]      rem_reg;
    logic [DUTY_W-1:0]      q_reg;

    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [PHASE_W-1:0]     out_user_reg;
    logic                   out_last_reg;

    logic                   in_fire;
    logic [DUTY_W-1:0]      in_tgt [4];
    logic [DUR_W-1:0]       in_dur;

    // tick bookkeeping
    logic [DUR_W-1:0]       len;
    logic [DUR_W-1:0]       step_inc;
    logic [DUR_W-1:0]       tick_div;
    logic [PHASE_W-1:0]     phase_after;

    // start bookkeeping
    logic [PROD_W-1:0]      prod;
    logic [RAMP_W-1:0]      ramp_new;
    logic [DUR_W-1:0]       hold_new;
    logic [PHASE_W-1:0]     first_ph;

    // divider datapath
    logic [DUTY_W-1:0]      cur_sel, tgt_sel, num, num_sh;
    logic [DUR_W:0]         r1, r2, d_ext;
    logic                   ge1, ge2;
    logic [DUTY_W-1:0]      rem1, rem2;
    logic [DUTY_W-1:0]      q_full;
    logic [DUTY_W:0]        sum_up;
    logic [DUTY_W-1:0]      duty_new;
    logic                   div_last_step;
    logic                   div_last_ch;
    logic                   out_free;
    logic [OUT_DATA_W-1:0]  shown;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            in_tgt[c] = s_axis_tdata[c*DUTY_W +: DUTY_W];
        end
        in_dur = s_axis_tdata[4*DUTY_W +: DUR_W];
    end

    // tick: divisor from the state before the step, then advance the step
    always_comb
    begin
        len      = (phase_reg == PH_HOLD) ? hold_reg : {{(DUR_W-RAMP_W){1'b0}}, ramp_reg};
        step_inc = step_reg + 1'b1;
        if (step_reg >= len)
        begin
            tick_div = {{(DUR_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            tick_div = len - step_reg;
        end
        unique case (phase_reg)
            PH_UP:   phase_after = (hold_reg != '0) ? PH_HOLD : PH_DOWN;
            PH_HOLD: phase_after = (ramp_reg != '0) ? PH_DOWN : PH_IDLE;
            default: phase_after = PH_IDLE;
        endcase
    end

    // start: ramp = duration / 10 by reciprocal multiply
    always_comb
    begin
        prod     = {{RECIP_W{1'b0}}, dur_reg} * {{DUR_W{1'b0}}, RECIP_TEN};
        ramp_new = prod[RECIP_SHIFT +: RAMP_W];
        hold_new = dur_reg - {{(DUR_W-RAMP_W-1){1'b0}}, ramp_new, 1'b0};
        if (ramp_new != '0)
        begin
            first_ph = PH_UP;
        end
        else if (hold_new != '0)
        begin
            first_ph = PH_HOLD;
        end
        else
        begin
            first_ph = PH_IDLE;
        end
    end

    // shared restoring divider, two bits per cycle
    always_comb
    begin
        cur_sel = cur_reg[ch_reg];
        tgt_sel = tgt_reg[ch_reg];
        if (op_up_reg)
        begin
            num = (tgt_sel > cur_sel) ? (tgt_sel - cur_sel) : '0;
        end
        else
        begin
            num = cur_sel;
        end
        num_sh = num << {cnt_reg, 1'b0};
        d_ext  = {1'b0, divisor_reg};
        r1     = {{(DUR_W-DUTY_W){1'b0}}, rem_reg, num_sh[DUTY_W-1]};
        ge1    = (r1 >= d_ext);
        rem1   = ge1 ? DUTY_W'(r1 - d_ext) : r1[DUTY_W-1:0];
        r2     = {{(DUR_W-DUTY_W){1'b0}}, rem1, num_sh[DUTY_W-2]};
        ge2    = (r2 >= d_ext);
        rem2   = ge2 ? DUTY_W'(r2 - d_ext) : r2[DUTY_W-1:0];
        q_full = {q_reg[DUTY_W-3:0], ge1, ge2};
        sum_up = {1'b0, cur_sel} + {1'b0, q_full};
        if (op_up_reg)
        begin
            duty_new = (sum_up > {1'b0, tgt_sel}) ? tgt_sel : sum_up[DUTY_W-1:0];
        end
        else
        begin
            duty_new = cur_sel - q_full;
        end
        div_last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        div_last_ch   = (ch_reg == CH_W'(CHANNELS - 1));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == CMD_START)
                    begin
                        state_next = ST_START;
                    end
                    else if (phase_reg == PH_UP || phase_reg == PH_DOWN)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_START:
            begin
                state_next = ST_FINISH;
            end
            ST_DIV:
            begin
                if (div_last_step && div_last_ch)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            ramp_reg  <= '0;
            hold_reg  <= '0;
            done_reg  <= 1'b0;
            show_reg  <= SHOW_ZERO;
            ch_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_fire)
            begin
                ch_reg  <= '0;
                cnt_reg <= '0;
                if (s_axis_tuser == CMD_START)
                begin
                    step_reg <= '0;
                    show_reg <= SHOW_ZERO;
                end
                else if (phase_reg == PH_IDLE)
                begin
                    show_reg <= SHOW_ZERO;
                    done_reg <= 1'b0;
                end
                else
                begin
                    show_reg <= (phase_reg == PH_HOLD) ? SHOW_TARGET : SHOW_DUTY;
                    if (step_inc >= len)
                    begin
                        step_reg  <= '0;
                        phase_reg <= phase_after;
                        done_reg  <= (phase_after == PH_IDLE);
                    end
                    else
                    begin
                        step_reg <= step_inc;
                        done_reg <= 1'b0;
                    end
                end
            end
            else if (state_reg == ST_START)
            begin
                ramp_reg  <= ramp_new;
                hold_reg  <= hold_new;
                phase_reg <= first_ph;
                done_reg  <= (first_ph == PH_IDLE);
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (div_last_step && !div_last_ch)
                begin
                    ch_reg <= ch_reg + 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire)
        begin
            dur_reg     <= in_dur;
            divisor_reg <= tick_div;
            op_up_reg   <= (phase_reg == PH_UP);
            rem_reg     <= '0;
            q_reg       <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= div_last_step ? '0 : rem2;
            q_reg   <= div_last_step ? '0 : q_full;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_chan
        always_ff @(posedge clk)
        begin
            if (state_reg == ST_IDLE && in_fire && s_axis_tuser == CMD_START)
            begin
                cur_reg[c] <= '0;
                if (c < 4)
                begin
                    tgt_reg[c] <= in_tgt[c % 4];
                end
                else
                begin
                    tgt_reg[c] <= '0;
                end
            end
            else if (state_reg == ST_DIV && div_last_step && ch_reg == CH_W'(c))
            begin
                cur_reg[c] <= duty_new;
            end
        end
    end

    for (genvar c = 0; c < OUT_CH; c++)
    begin : g_show
        if (c < CHANNELS)
        begin : g_live
            always_comb
            begin
                case (show_reg)
                    SHOW_TARGET: shown[c*DUTY_W +: DUTY_W] = tgt_reg[c];
                    SHOW_DUTY:   shown[c*DUTY_W +: DUTY_W] = cur_reg[c];
                    default:     shown[c*DUTY_W +: DUTY_W] = '0;
                endcase
            end
        end
        else
        begin : g_none
            assign shown[c*DUTY_W +: DUTY_W] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH && out_free)
        begin
            out_data_reg <= shown;
            out_user_reg <= phase_reg;
            out_last_reg <= done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (divisor_reg != '0))
        else $error("divider running with zero divisor");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({{(DUR_W-DUTY_W){1'b0}}, rem_reg} < divisor_reg))
        else $error("partial remainder not below divisor");

    a_ramp_phase_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && (phase_reg == PH_UP || phase_reg == PH_DOWN))
        |-> (ramp_reg != '0 && {{(DUR_W-RAMP_W){1'b0}}, ramp_reg} > step_reg))
        else $error("ramp phase with step past its length");

    a_hold_phase_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && phase_reg == PH_HOLD) |-> (hold_reg > step_reg))
        else $error("hold phase with step past its length");

    a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == PH_IDLE))
        else $error("move finished but phase not idle");
`endif

endmodule
